/* rtl/utf8_to_ascii_text_sanitizer_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text sanitizer
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_ASCII_TEXT_SANITIZER_TOP_DEFINES_SVH
`define UTF8_TO_ASCII_TEXT_SANITIZER_TOP_DEFINES_SVH

// same-cycle implication
`define UTS_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define UTS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/uts_pkg.sv */
// ----------------------------------------------------------------------------
// uts_pkg
// Types, constants and lookup functions of the text sanitizer.
// ----------------------------------------------------------------------------
`default_nettype none

package uts_pkg;

  localparam int unsigned ENT_DEPTH  = 5;
  localparam int unsigned EC_W       = $clog2(ENT_DEPTH + 1);
  localparam int unsigned RI_W       = $clog2(ENT_DEPTH);
  localparam int unsigned NUM_ENT    = 7;
  localparam int unsigned ENT_MAXLEN = 5;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_AMP   = 7'h26;
  localparam logic [6:0] CH_QMARK = 7'h3F;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_QUOTE = 7'h22;
  localparam logic [6:0] CH_APOS  = 7'h27;
  localparam logic [6:0] CH_DASH  = 7'h2D;
  localparam logic [7:0] MAX_CHARS_RST = 8'd199;

  // entity bodies after '&': quot; amp; lt; gt; #039; #39; apos;
  localparam logic [6:0] ENT_BODY [NUM_ENT][ENT_MAXLEN] = '{
    '{7'h71, 7'h75, 7'h6F, 7'h74, 7'h3B},
    '{7'h61, 7'h6D, 7'h70, 7'h3B, 7'h00},
    '{7'h6C, 7'h74, 7'h3B, 7'h00, 7'h00},
    '{7'h67, 7'h74, 7'h3B, 7'h00, 7'h00},
    '{7'h23, 7'h30, 7'h33, 7'h39, 7'h3B},
    '{7'h23, 7'h33, 7'h39, 7'h3B, 7'h00},
    '{7'h61, 7'h70, 7'h6F, 7'h73, 7'h3B}
  };
  localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5};
  localparam logic [6:0] ENT_GLYPH [NUM_ENT] = '{
    CH_QUOTE, CH_AMP, 7'h3C, 7'h3E, CH_APOS, CH_APOS, CH_APOS
  };

  typedef enum logic [1:0] {EM_NONE, EM_PREFIX, EM_FULL} match_e;
  typedef enum logic [1:0] {MK_CHAR, MK_SPACE, MK_DOTS} map_kind_e;
  typedef enum logic [2:0] {FC_SPACE, FC_AMP, FC_PRINT, FC_LEAD, FC_BAD} fresh_e;
  typedef enum logic [2:0] {
    PS_MAP, PS_GLYPH, PS_BYTE, PS_QMARK, PS_AMP, PS_HELD, PS_DOTS
  } put_src_e;
  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK_UTF, ST_CHK_ENT, ST_FRESH, ST_END_UTF, ST_END_ENT,
    ST_MAP, ST_PUT, ST_RPL_AMP, ST_RPL, ST_FIN
  } state_e;

  typedef struct packed {
    match_e     res;
    logic [6:0] glyph;
  } ent_match_t;

  typedef struct packed {
    map_kind_e  kind;
    logic [6:0] ch;
  } map_t;

  typedef struct packed {
    logic     load;
    logic     utf_cont;
    logic     utf_abort;
    logic     ent_store;
    logic     ent_inc;
    logic     ent_clear;
    logic     ent_start;
    logic     take_sp;
    logic     lead;
    logic     set_put;
    put_src_e src;
    logic     put_step;
    logic     ri_clr;
    logic     ri_inc;
    logic     fin;
  } dp_cmd_t;

  typedef struct packed {
    logic      present;
    logic      eos;
    logic      cl_nz;
    logic      cl_last;
    logic      is_cont;
    logic      ec_nz;
    match_e    em;
    map_kind_e mk;
    fresh_e    fc;
    logic      put_done;
    logic      can_go;
    logic      rpl_more;
  } dp_stat_t;

  // held bytes are stored ones below held-1, the current byte at held-1
  function automatic ent_match_t ent_match(input logic [EC_W-1:0] held,
                                           input logic [6:0] held_b [ENT_DEPTH],
                                           input logic [7:0] cur);
    ent_match_t r;
    logic       same;
    logic [7:0] bi;
    r.res   = EM_NONE;
    r.glyph = CH_QMARK;
    for (int k = 0; k < NUM_ENT; k++) begin
      same = int'(held) <= int'(ENT_LEN[k]);
      for (int i = 0; i < ENT_MAXLEN; i++) begin
        if (i < int'(held)) begin
          bi = (i == int'(held) - 1) ? cur : {1'b0, held_b[i]};
          if (bi != {1'b0, ENT_BODY[k][i]}) same = 1'b0;
        end
      end
      if (same) begin
        if (int'(held) == int'(ENT_LEN[k])) begin
          if (r.res != EM_FULL) begin
            r.res   = EM_FULL;
            r.glyph = ENT_GLYPH[k];
          end
        end else if (r.res == EM_NONE) begin
          r.res = EM_PREFIX;
        end
      end
    end
    return r;
  endfunction

  function automatic map_t map_cp(input logic [20:0] cp);
    map_t r;
    r.kind = MK_CHAR;
    r.ch   = CH_QMARK;
    case (cp)
      21'h2018, 21'h2019, 21'h201B, 21'h2032: r.ch = CH_APOS;
      21'h201C, 21'h201D, 21'h2033:           r.ch = CH_QUOTE;
      21'h2010, 21'h2011, 21'h2012, 21'h2013,
      21'h2014, 21'h2015, 21'h2212:           r.ch = CH_DASH;
      21'h2026:                               r.kind = MK_DOTS;
      21'h00A0, 21'h2009, 21'h200A, 21'h202F: r.kind = MK_SPACE;
      21'h00E9, 21'h00E8, 21'h00EA, 21'h00EB: r.ch = 7'h65;
      21'h00E1, 21'h00E0, 21'h00E2, 21'h00E4,
      21'h00E3, 21'h00E5:                     r.ch = 7'h61;
      21'h00ED, 21'h00EC, 21'h00EE, 21'h00EF: r.ch = 7'h69;
      21'h00F3, 21'h00F2, 21'h00F4, 21'h00F6,
      21'h00F5:                               r.ch = 7'h6F;
      21'h00FA, 21'h00F9, 21'h00FB, 21'h00FC: r.ch = 7'h75;
      21'h00F1:                               r.ch = 7'h6E;
      21'h00E7:                               r.ch = 7'h63;
      default:                                r.ch = CH_QMARK;
    endcase
    return r;
  endfunction

  function automatic fresh_e classify(input logic [7:0] b);
    fresh_e r;
    if (b inside {8'h20, 8'h0A, 8'h0D, 8'h09}) r = FC_SPACE;
    else if (b == 8'h26)                      r = FC_AMP;
    else if (b inside {[8'h21:8'h7E]})        r = FC_PRINT;
    else if (b >= 8'hC0)                      r = FC_LEAD;
    else                                      r = FC_BAD;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/uts_ifs.sv */
// ----------------------------------------------------------------------------
// uts channel interfaces
// Byte input, character output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface uts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_present;
  logic       end_of_string;
  modport source (output valid, in_byte, byte_present, end_of_string, input ready);
  modport sink   (input valid, in_byte, byte_present, end_of_string, output ready);
endinterface

interface uts_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       char_valid;
  logic       end_of_text;
  modport source (output valid, out_char, char_valid, end_of_text, input ready);
  modport sink   (input valid, out_char, char_valid, end_of_text, output ready);
endinterface

interface uts_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/uts_ctrl.sv */
// ----------------------------------------------------------------------------
// uts_ctrl
// Sequencer: walks one input beat through decode, entity and flush steps.
// ----------------------------------------------------------------------------
`default_nettype none

module uts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uts_pkg::dp_stat_t  stat_i,
  output uts_pkg::dp_cmd_t   cmd_o
);
  import uts_pkg::*;

  state_e state_q, state_d;
  state_e map_ret_q, map_ret_d;
  state_e put_ret_q, put_ret_d;
  state_e rpl_ret_q, rpl_ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      map_ret_q <= ST_IDLE;
      put_ret_q <= ST_IDLE;
      rpl_ret_q <= ST_IDLE;
    end else begin
      state_q   <= state_d;
      map_ret_q <= map_ret_d;
      put_ret_q <= put_ret_d;
      rpl_ret_q <= rpl_ret_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    map_ret_d = map_ret_q;
    put_ret_d = put_ret_q;
    rpl_ret_d = rpl_ret_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CHK_UTF;
      ST_CHK_UTF: begin
        if (!stat_i.present) begin
          state_d = ST_END_UTF;
        end else if (stat_i.cl_nz) begin
          if (stat_i.is_cont) begin
            if (stat_i.cl_last) begin
              map_ret_d = ST_END_UTF;
              state_d   = ST_MAP;
            end else begin
              state_d = ST_END_UTF;
            end
          end else begin
            map_ret_d = ST_CHK_ENT;
            state_d   = ST_MAP;
          end
        end else if (stat_i.ec_nz) begin
          state_d = ST_CHK_ENT;
        end else begin
          state_d = ST_FRESH;
        end
      end
      ST_CHK_ENT: begin
        if (!stat_i.ec_nz) begin
          state_d = ST_FRESH;
        end else begin
          case (stat_i.em)
            EM_FULL: begin
              put_ret_d = ST_END_UTF;
              state_d   = ST_PUT;
            end
            EM_PREFIX: state_d = ST_END_UTF;
            default: begin
              rpl_ret_d = ST_FRESH;
              state_d   = ST_RPL_AMP;
            end
          endcase
        end
      end
      ST_FRESH: begin
        if (stat_i.fc == FC_PRINT || stat_i.fc == FC_BAD) begin
          put_ret_d = ST_END_UTF;
          state_d   = ST_PUT;
        end else begin
          state_d = ST_END_UTF;
        end
      end
      ST_END_UTF: begin
        if (!stat_i.eos) begin
          state_d = ST_FIN;
        end else if (stat_i.cl_nz) begin
          map_ret_d = ST_END_ENT;
          state_d   = ST_MAP;
        end else begin
          state_d = ST_END_ENT;
        end
      end
      ST_END_ENT: begin
        if (stat_i.ec_nz) begin
          rpl_ret_d = ST_FIN;
          state_d   = ST_RPL_AMP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MAP: begin
        if (stat_i.mk == MK_SPACE) begin
          state_d = map_ret_q;
        end else begin
          put_ret_d = map_ret_q;
          state_d   = ST_PUT;
        end
      end
      ST_PUT: if (stat_i.can_go && stat_i.put_done) state_d = put_ret_q;
      ST_RPL_AMP: begin
        put_ret_d = ST_RPL;
        state_d   = ST_PUT;
      end
      ST_RPL: begin
        if (stat_i.rpl_more) begin
          put_ret_d = ST_RPL;
          state_d   = ST_PUT;
        end else begin
          state_d = rpl_ret_q;
        end
      end
      ST_FIN: if (stat_i.can_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.src  = PS_QMARK;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHK_UTF: begin
        if (stat_i.present && stat_i.cl_nz) begin
          if (stat_i.is_cont) cmd_o.utf_cont = 1'b1;
          else                cmd_o.utf_abort = 1'b1;
        end
      end
      ST_CHK_ENT: begin
        if (stat_i.ec_nz) begin
          cmd_o.ent_store = 1'b1;
          case (stat_i.em)
            EM_FULL: begin
              cmd_o.ent_clear = 1'b1;
              cmd_o.set_put   = 1'b1;
              cmd_o.src       = PS_GLYPH;
            end
            EM_PREFIX: cmd_o.ent_inc = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FRESH: begin
        case (stat_i.fc)
          FC_SPACE: cmd_o.take_sp = 1'b1;
          FC_AMP:   cmd_o.ent_start = 1'b1;
          FC_PRINT: begin
            cmd_o.set_put = 1'b1;
            cmd_o.src     = PS_BYTE;
          end
          FC_LEAD:  cmd_o.lead = 1'b1;
          default: begin
            cmd_o.set_put = 1'b1;
            cmd_o.src     = PS_QMARK;
          end
        endcase
      end
      ST_END_UTF: cmd_o.utf_abort = stat_i.eos && stat_i.cl_nz;
      ST_MAP: begin
        case (stat_i.mk)
          MK_SPACE: cmd_o.take_sp = 1'b1;
          MK_DOTS: begin
            cmd_o.set_put = 1'b1;
            cmd_o.src     = PS_DOTS;
          end
          default: begin
            cmd_o.set_put = 1'b1;
            cmd_o.src     = PS_MAP;
          end
        endcase
      end
      ST_PUT: cmd_o.put_step = stat_i.can_go;
      ST_RPL_AMP: begin
        cmd_o.set_put = 1'b1;
        cmd_o.src     = PS_AMP;
        cmd_o.ri_clr  = 1'b1;
      end
      ST_RPL: begin
        if (stat_i.rpl_more) begin
          cmd_o.set_put = 1'b1;
          cmd_o.src     = PS_HELD;
          cmd_o.ri_inc  = 1'b1;
        end else begin
          cmd_o.ent_clear = 1'b1;
        end
      end
      ST_FIN: cmd_o.fin = stat_i.can_go;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/uts_dp.sv */
// ----------------------------------------------------------------------------
// uts_dp
// Datapath: decode state, entity hold buffer, character put unit, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module uts_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uts_pkg::dp_cmd_t  cmd_i,
  output uts_pkg::dp_stat_t stat_o,
  input  logic [7:0]        in_byte_i,
  input  logic              byte_present_i,
  input  logic              end_of_string_i,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        out_char_o,
  output logic              char_valid_o,
  output logic              end_of_text_o
);
  import uts_pkg::*;

  // control state
  logic            after_space_q, after_space_d;
  logic            space_owed_q, space_owed_d;
  logic [7:0]      cw_q, cw_d;
  logic [7:0]      max_q;
  logic [EC_W-1:0] ec_q, ec_d;
  logic [1:0]      cl_q, cl_d;
  logic [1:0]      rep_q, rep_d;
  logic [RI_W-1:0] ri_q, ri_d;
  logic            pend_v_q, pend_v_d;
  logic            out_v_q, out_v_d;
  // payload
  logic [7:0]      b_q;
  logic            pres_q, eos_q;
  logic [20:0]     cp_q, cp_d;
  logic [6:0]      ent_q [ENT_DEPTH];
  logic [6:0]      put_c_q, put_c_d;
  logic [6:0]      pend_c_q, pend_c_d;
  logic [6:0]      out_c_q, out_c_d;
  logic            out_cv_q, out_cv_d;
  logic            out_eot_q, out_eot_d;

  ent_match_t      em;
  map_t            mp;
  logic            room, can_go, emit, push;
  logic [6:0]      emit_c, sel_c;
  logic [1:0]      ext;
  logic [EC_W-1:0] ec_m1;

  assign em     = ent_match(ec_q, ent_q, b_q);
  assign mp     = map_cp(cp_q);
  assign room   = cw_q < max_q;
  assign can_go = !out_v_q || out_ready_i;
  assign ec_m1  = ec_q - EC_W'(1);
  assign ext    = (b_q >= 8'hF0) ? 2'd3 : ((b_q >= 8'hE0) ? 2'd2 : 2'd1);

  assign stat_o.present  = pres_q;
  assign stat_o.eos      = eos_q;
  assign stat_o.cl_nz    = cl_q != 2'd0;
  assign stat_o.cl_last  = cl_q == 2'd1;
  assign stat_o.is_cont  = b_q[7:6] == 2'b10;
  assign stat_o.ec_nz    = ec_q != '0;
  assign stat_o.em       = em.res;
  assign stat_o.mk       = mp.kind;
  assign stat_o.fc       = classify(b_q);
  assign stat_o.put_done = !space_owed_q && (rep_q == 2'd1);
  assign stat_o.can_go   = can_go;
  assign stat_o.rpl_more = (int'(ri_q) + 1) < int'(ec_q);

  always_comb begin
    case (cmd_i.src)
      PS_MAP:   sel_c = mp.ch;
      PS_GLYPH: sel_c = em.glyph;
      PS_BYTE:  sel_c = b_q[6:0];
      PS_AMP:   sel_c = CH_AMP;
      PS_HELD:  sel_c = ent_q[ri_q];
      PS_DOTS:  sel_c = CH_DOT;
      default:  sel_c = CH_QMARK;
    endcase
  end

  always_comb begin
    after_space_d = after_space_q;
    space_owed_d  = space_owed_q;
    cw_d          = cw_q;
    ec_d          = ec_q;
    cl_d          = cl_q;
    cp_d          = cp_q;
    rep_d         = rep_q;
    ri_d          = ri_q;
    put_c_d       = put_c_q;
    pend_v_d      = pend_v_q;
    pend_c_d      = pend_c_q;
    out_v_d       = out_v_q;
    out_c_d       = out_c_q;
    out_cv_d      = out_cv_q;
    out_eot_d     = out_eot_q;
    emit          = 1'b0;
    emit_c        = put_c_q;
    push          = 1'b0;

    if (out_v_q && out_ready_i) out_v_d = 1'b0;

    if (cmd_i.utf_cont) begin
      cp_d = {cp_q[14:0], b_q[5:0]};
      cl_d = cl_q - 2'd1;
    end
    if (cmd_i.utf_abort) cl_d = 2'd0;
    if (cmd_i.lead) begin
      cp_d = 21'(b_q[5:0] & (6'h3F >> ext));
      cl_d = ext;
    end
    if (cmd_i.ent_inc)   ec_d = ec_q + EC_W'(1);
    if (cmd_i.ent_clear) ec_d = '0;
    if (cmd_i.ent_start) ec_d = EC_W'(1);
    if (cmd_i.take_sp) begin
      if (!after_space_q) space_owed_d = 1'b1;
      after_space_d = 1'b1;
    end
    if (cmd_i.set_put) begin
      put_c_d = sel_c;
      rep_d   = (cmd_i.src == PS_DOTS) ? 2'd3 : 2'd1;
    end
    if (cmd_i.ri_clr) ri_d = '0;
    if (cmd_i.ri_inc) ri_d = ri_q + RI_W'(1);

    // put unit: an owed space goes first, then the character
    if (cmd_i.put_step) begin
      if (space_owed_q) begin
        space_owed_d = 1'b0;
        if (room) begin
          cw_d = cw_q + 8'd1;
          // a space on the last slot is trailing and is dropped
          if (cw_q + 8'd1 < max_q) begin
            emit   = 1'b1;
            emit_c = CH_SPACE;
          end
        end
      end else begin
        if (room) begin
          emit = 1'b1;
          cw_d = cw_q + 8'd1;
        end
        after_space_d = 1'b0;
        rep_d         = rep_q - 2'd1;
      end
    end

    // one character is held back so the last one of a string can carry the end flag
    if (emit) begin
      if (pend_v_q) begin
        push      = 1'b1;
        out_c_d   = pend_c_q;
        out_cv_d  = 1'b1;
        out_eot_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_c_d = emit_c;
    end

    if (cmd_i.fin) begin
      if (pend_v_q) begin
        push      = 1'b1;
        out_c_d   = pend_c_q;
        out_cv_d  = 1'b1;
        out_eot_d = eos_q;
        pend_v_d  = 1'b0;
      end else if (eos_q) begin
        push      = 1'b1;
        out_c_d   = 7'h00;
        out_cv_d  = 1'b0;
        out_eot_d = 1'b1;
      end
      if (eos_q) begin
        after_space_d = 1'b1;
        space_owed_d  = 1'b0;
        cw_d          = 8'd0;
        ec_d          = '0;
        cl_d          = 2'd0;
        cp_d          = 21'd0;
      end
    end

    if (push) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_space_q <= 1'b1;
      space_owed_q  <= 1'b0;
      cw_q          <= 8'd0;
      max_q         <= MAX_CHARS_RST;
      ec_q          <= '0;
      cl_q          <= 2'd0;
      cp_q          <= 21'd0;
      rep_q         <= 2'd1;
      ri_q          <= '0;
      pend_v_q      <= 1'b0;
      out_v_q       <= 1'b0;
    end else begin
      after_space_q <= after_space_d;
      space_owed_q  <= space_owed_d;
      cw_q          <= cw_d;
      if (cfg_valid_i) max_q <= cfg_data_i;
      ec_q          <= ec_d;
      cl_q          <= cl_d;
      cp_q          <= cp_d;
      rep_q         <= rep_d;
      ri_q          <= ri_d;
      pend_v_q      <= pend_v_d;
      out_v_q       <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      b_q    <= in_byte_i;
      pres_q <= byte_present_i;
      eos_q  <= end_of_string_i;
    end
    if (cmd_i.ent_store) ent_q[ec_m1[RI_W-1:0]] <= b_q[6:0];
    put_c_q   <= put_c_d;
    pend_c_q  <= pend_c_d;
    out_c_q   <= out_c_d;
    out_cv_q  <= out_cv_d;
    out_eot_q <= out_eot_d;
  end

  assign out_valid_o   = out_v_q;
  assign out_char_o    = out_c_q;
  assign char_valid_o  = out_cv_q;
  assign end_of_text_o = out_eot_q;

endmodule

`default_nettype wire

/* rtl/utf8_to_ascii_text_sanitizer_top.sv */
// ----------------------------------------------------------------------------
// utf8_to_ascii_text_sanitizer_top
// Turns a UTF-8 / HTML-entity byte stream into printable ASCII for a display.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch: one byte beat per item (in_byte, byte_present, end_of_string).
//    byte_present low with end_of_string high flushes the string.
//  - out_ch: one character beat per result; the last beat of a string has
//    end_of_text set, and a string that yields nothing gives one empty beat.
//  - cfg_ch: writes max_chars (reset 199); ready is always high. Write only
//    while the block is idle.
//  - Processing: one item at a time. A plain ASCII byte goes through the
//    accept, decode, classify, put, end check and flush steps. An owed space
//    adds a put step, a completed UTF-8 sequence a map step, "..." a put
//    step per extra dot, and an entity mismatch RPL_AMP, put and RPL for the
//    '&' plus a put and RPL step per replayed byte. The put unit emits at
//    most one character per cycle.
//  - Output: an item's last character appears the cycle after the flush step.
//  - Stall: while the output register is full and out_ch.ready is low, the
//    put and flush steps wait; in_ch.ready stays low until the item is done.
//  - Reset: asynchronous, active low; clears string state, max_chars to 199.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_to_ascii_text_sanitizer_top_defines.svh"

module utf8_to_ascii_text_sanitizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  uts_in_if.sink     in_ch,
  uts_out_if.source  out_ch,
  uts_cfg_if.sink    cfg_ch
);
  import uts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  // sequencer: one state per processing step of a beat
  uts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: holds decode state, entity bytes, pending char and output reg
  uts_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_byte_i       (in_ch.in_byte),
    .byte_present_i  (in_ch.byte_present),
    .end_of_string_i (in_ch.end_of_string),
    .cfg_valid_i     (cfg_ch.valid),
    .cfg_data_i      (cfg_ch.data),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_char_o      (out_ch.out_char),
    .char_valid_o    (out_ch.char_valid),
    .end_of_text_o   (out_ch.end_of_text)
  );

  // characters are always printable
  `UTS_ASSERT_IMPL(a_printable, out_ch.valid && out_ch.char_valid, (out_ch.out_char >= 7'h20) && (out_ch.out_char <= 7'h7E), "non-printable character beat")
  // an empty beat only marks a string end
  `UTS_ASSERT_IMPL(a_marker, out_ch.valid && !out_ch.char_valid, out_ch.end_of_text && (out_ch.out_char == 7'h00), "malformed end marker")
  // a new beat is not taken while one is being worked on
  `UTS_ASSERT_NEXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while busy")

endmodule

`default_nettype wire

/* tb/utf8_to_ascii_text_sanitizer_top_test.sv */
// ----------------------------------------------------------------------------
// Text sanitizer testbench
// Drives byte beats with random gaps and checks every character beat against
// a built-in predictor. The run passes through several max_chars settings.
// ----------------------------------------------------------------------------
module utf8_to_ascii_text_sanitizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import uts_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       present;
    logic       eos;
  } byte_item_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       cv;
    logic       eot;
  } char_beat_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  uts_in_if  in_ch();
  uts_out_if out_ch();
  uts_cfg_if cfg_ch();

  utf8_to_ascii_text_sanitizer_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Predictor state: a private copy of the sanitizer's string state.
  logic [7:0]  lim_chars;
  logic        prev_space;
  logic        pend_space;
  int unsigned emitted;
  logic [7:0]  held_bytes [ENT_DEPTH];
  int unsigned amp_depth;
  logic [20:0] cp_acc;
  int unsigned cont_left;

  byte_item_t  pending_bytes [$];
  char_beat_t  expected_chars [$];
  char_beat_t  step_out [$];
  int          mismatches = 0;
  int          beats_checked = 0;
  int          items_sent = 0;
  bit          hold_sink = 1'b0;
  bit          stim_done = 1'b0;
  bit          in_fire = 1'b0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic void push_beat(input logic [6:0] c, input logic v);
    char_beat_t r;
    r.ch = c; r.cv = v; r.eot = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void put_char(input logic [6:0] c);
    bit lead;
    lead = 0;
    if (pend_space) begin
      pend_space = 0;
      if (emitted < lim_chars) begin
        emitted++; lead = 1;
      end
    end
    if (emitted < lim_chars) begin
      if (lead) push_beat(CH_SPACE, 1'b1);
      push_beat(c, 1'b1);
      emitted++;
    end
    prev_space = 0;
  endfunction

  function automatic void owe_space();
    if (!prev_space) pend_space = 1;
    prev_space = 1;
  endfunction

  function automatic void translit(input logic [20:0] cp);
    case (cp)
      21'h2018, 21'h2019, 21'h201B, 21'h2032: put_char(7'h27);
      21'h201C, 21'h201D, 21'h2033: put_char(7'h22);
      21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2015, 21'h2212:
        put_char(7'h2D);
      21'h2026: begin
        put_char(7'h2E); put_char(7'h2E); put_char(7'h2E);
      end
      21'h00A0, 21'h2009, 21'h200A, 21'h202F: owe_space();
      21'h00E9, 21'h00E8, 21'h00EA, 21'h00EB: put_char(7'h65);
      21'h00E1, 21'h00E0, 21'h00E2, 21'h00E4, 21'h00E3, 21'h00E5: put_char(7'h61);
      21'h00ED, 21'h00EC, 21'h00EE, 21'h00EF: put_char(7'h69);
      21'h00F3, 21'h00F2, 21'h00F4, 21'h00F6, 21'h00F5: put_char(7'h6F);
      21'h00FA, 21'h00F9, 21'h00FB, 21'h00FC: put_char(7'h75);
      21'h00F1: put_char(7'h6E);
      21'h00E7: put_char(7'h63);
      default: put_char(7'h3F);
    endcase
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    if (b == 8'h20 || b == 8'h0A || b == 8'h0D || b == 8'h09) owe_space();
    else if (b == 8'h26) amp_depth = 1;
    else if (b > 8'h20 && b < 8'h7F) put_char(b[6:0]);
    else if (b >= 8'hC0) begin
      cont_left = (b >= 8'hF0) ? 3 : ((b >= 8'hE0) ? 2 : 1);
      cp_acc = 21'(b & (8'h3F >> cont_left));
    end else put_char(7'h3F);
  endfunction

  function automatic void flush_amp();
    put_char(7'h26);
    for (int i = 0; i + 1 < amp_depth && i < ENT_DEPTH; i++) put_char(held_bytes[i][6:0]);
    amp_depth = 0;
  endfunction

  // 0 no match, 1 prefix, 2 complete; glyph returned on a complete match
  function automatic int entity_lookup(input int n, output logic [6:0] g);
    string names [7] = '{"quot;", "amp;", "lt;", "gt;", "#039;", "#39;", "apos;"};
    logic [6:0] glyphs [7] = '{7'h22, 7'h26, 7'h3C, 7'h3E, 7'h27, 7'h27, 7'h27};
    int best;
    bit same;
    best = 0; g = 7'h3F;
    for (int k = 0; k < 7; k++) begin
      same = n <= names[k].len();
      for (int i = 0; same && i < n; i++)
        if (held_bytes[i] != 8'(names[k][i])) same = 0;
      if (same) begin
        if (n == names[k].len()) begin
          g = glyphs[k]; return 2;
        end
        best = 1;
      end
    end
    return best;
  endfunction

  function automatic void sanitize_byte(input logic [7:0] b);
    int m;
    logic [6:0] g;
    if (cont_left > 0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left--;
        if (cont_left == 0) translit(cp_acc);
        return;
      end
      cont_left = 0;
      translit(cp_acc);
    end
    if (amp_depth > 0) begin
      m = 0;
      if (amp_depth - 1 < ENT_DEPTH) begin
        held_bytes[amp_depth - 1] = b;
        m = entity_lookup(amp_depth, g);
      end
      if (m == 2) begin
        amp_depth = 0; put_char(g);
      end else if (m == 1) amp_depth++;
      else begin
        flush_amp(); plain_byte(b);
      end
      return;
    end
    plain_byte(b);
  endfunction

  function automatic void clear_string();
    prev_space = 1; pend_space = 0; emitted = 0;
    amp_depth = 0; cp_acc = '0; cont_left = 0;
  endfunction

  // Works out the beats that one accepted byte item produces.
  function automatic void predict_item(input byte_item_t it);
    step_out.delete();
    if (it.present) sanitize_byte(it.b);
    if (it.eos) begin
      if (cont_left > 0) begin
        cont_left = 0; translit(cp_acc);
      end
      if (amp_depth > 0) flush_amp();
      if (step_out.size() == 0) push_beat(7'h00, 1'b0);
      step_out[step_out.size() - 1].eot = 1'b1;
      clear_string();
    end
    foreach (step_out[i]) expected_chars.push_back(step_out[i]);
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic void add_byte(input logic [7:0] b, input bit eos = 0);
    byte_item_t it;
    it.b = b; it.present = 1; it.eos = eos;
    pending_bytes.push_back(it);
  endfunction

  function automatic void add_end();
    byte_item_t it;
    it.b = 8'($urandom); it.present = 0; it.eos = 1;
    pending_bytes.push_back(it);
  endfunction

  function automatic void add_text(input string s, input bit eos = 1);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], eos && i == s.len() - 1);
  endfunction

  function automatic void add_utf8(input int cp);
    if (cp < 'h800) begin
      add_byte(8'(8'hC0 | (cp >> 6))); add_byte(8'(8'h80 | (cp & 'h3F)));
    end else begin
      add_byte(8'(8'hE0 | (cp >> 12))); add_byte(8'(8'h80 | ((cp >> 6) & 'h3F)));
      add_byte(8'(8'h80 | (cp & 'h3F)));
    end
  endfunction

  // one random piece: a byte, entity text, UTF-8 sequence or empty item
  function automatic void add_random_piece();
    int cps [12] = '{'h2018, 'h201D, 'h2014, 'h2026, 'h00A0, 'h202F, 'h00E9,
                     'h00E4, 'h00F1, 'h00E7, 'h2212, 'h0416};
    string ents [9] = '{"&quot;", "&amp;", "&lt;", "&gt;", "&#039;", "&#39;",
                        "&apos;", "&qu", "&#0x"};
    case ($urandom_range(0, 9))
      0, 1, 2: add_byte(8'($urandom_range(8'h21, 8'h7E)));
      3: add_byte($urandom_range(0, 1) ? 8'h20 : 8'h0A);
      4: add_text(ents[$urandom_range(0, 8)], 0);
      5: add_utf8(cps[$urandom_range(0, 11)]);
      6: add_byte(8'($urandom));
      7: add_byte(8'($urandom_range(8'hF0, 8'hFF)));
      8: add_byte(8'($urandom_range(8'h80, 8'hBF)));
      default: begin
        byte_item_t it;
        it.b = 8'($urandom); it.present = 0; it.eos = 0;
        pending_bytes.push_back(it);
      end
    endcase
  endfunction

  // ---------------- driver ----------------
  int src_gap = 0;
  bit src_pause = 1'b0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // hold the offered beat until it is taken
    end else if (src_gap > 0) begin
      src_gap--;
      in_ch.valid <= 1'b0;
    end else if (pending_bytes.size() > 0 && !src_pause) begin
      byte_item_t it;
      it = pending_bytes.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.in_byte <= it.b;
      in_ch.byte_present <= it.present;
      in_ch.end_of_string <= it.eos;
      src_gap = ($urandom_range(0, 3) == 0) ?
                (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    in_fire = rst_ni && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      predict_item({in_ch.in_byte, in_ch.byte_present, in_ch.end_of_string});
      items_sent++;
    end
  end

  // ---------------- sink: random stalls ----------------
  int snk_gap = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || hold_sink) begin
      out_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 4) == 0)
        snk_gap = ($urandom_range(0, 12) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      char_beat_t want;
      beats_checked++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char %h", out_ch.out_char));
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.out_char !== want.ch)
          report_mismatch($sformatf("out_char %h want %h", out_ch.out_char, want.ch));
        if (out_ch.char_valid !== want.cv)
          report_mismatch($sformatf("char_valid %b want %b", out_ch.char_valid, want.cv));
        if (out_ch.end_of_text !== want.eot)
          report_mismatch($sformatf("end_of_text %b want %b", out_ch.end_of_text, want.eot));
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_sink)
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress, %0d beats outstanding", expected_chars.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Wait until the block has drained, then give a byte in flight time to finish.
  task automatic drain();
    while (pending_bytes.size() > 0 || in_ch.valid || expected_chars.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    lim_chars = v;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_strings(input int n_bytes);
    int start;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < n_bytes) begin
      repeat ($urandom_range(1, 14)) add_random_piece();
      if ($urandom_range(0, 3) == 0) add_byte(8'h20, 1);
      else if ($urandom_range(0, 2) == 0) add_end();
      else add_byte(8'($urandom_range(8'h21, 8'h7E)), 1);
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.in_byte = 0; in_ch.byte_present = 0; in_ch.end_of_string = 0;
    out_ch.ready = 0; cfg_ch.valid = 0; cfg_ch.data = 0;
    lim_chars = MAX_CHARS_RST;
    foreach (held_bytes[i]) held_bytes[i] = 8'h00;
    clear_string();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: whitespace trim, entities, mismatch replay, utf-8 cases
    add_text("  a \t\r\nb  ");
    add_text("&quot;&amp;&lt;&gt;&#039;&#39;&apos;&ab&#03x&");
    add_byte(8'hE2); add_byte(8'h80); add_byte(8'hA6); add_byte(8'hC3);
    add_byte(8'h41); add_byte(8'hFF); add_byte(8'h80); add_byte(8'h00);
    add_byte(8'h7F); add_byte(8'hF0, 1);
    add_end();
    drain();

    write_limit(8'd0);
    add_text("xy z"); add_end();
    drain();
    write_limit(8'd3);
    add_text("ab cd"); add_text("abc d"); add_text("a&lt;&quo");
    drain();
    write_limit(8'd255);
    random_strings(100);
    drain();

    // long sink hold-off while the source keeps offering
    random_strings(40);
    hold_sink = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_sink = 1'b0;
    drain();

    write_limit(8'd5);
    random_strings(60);
    // source pauses until every result is in
    src_pause = 1'b1;
    while (expected_chars.size() > 0 || in_ch.valid) @(posedge clk_i);
    src_pause = 1'b0;
    drain();
    write_limit(8'd199);
    random_strings(40);
    drain();

    $display("Covered %0d byte items and %0d character beats over limits 0, 3, 5, 199, 255.",
             items_sent, beats_checked);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/uts_pkg.sv
rtl/uts_ifs.sv
rtl/uts_ctrl.sv
rtl/uts_dp.sv
rtl/utf8_to_ascii_text_sanitizer_top.sv
tb/utf8_to_ascii_text_sanitizer_top_test.sv
